/* sv/touch_tag_event_qualifier_macros.svh */
// Assertion macros used by the touch tag event qualifier checker
`ifndef TOUCH_TAG_EVENT_QUALIFIER_MACROS_SVH
`define TOUCH_TAG_EVENT_QUALIFIER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TTQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define TTQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ttq_pkg.sv */
// Package with types, codes and constants of the touch tag event qualifier
package ttq_pkg;

    localparam int NUM_SLOTS = 5;
    localparam int SLOT_W    = 3;
    localparam int TAG_W     = 8;
    localparam int COORD_W   = 16;
    localparam int TIME_W    = 32;
    localparam int HOLD_W    = 16;

    localparam logic [HOLD_W-1:0]         LONG_PRESS_RESET = 16'd1000;
    localparam logic signed [COORD_W-1:0] RELEASED_XY      = 16'sh8000;

    // slot modes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_PRESSED = 2'd1;
    localparam logic [1:0] MODE_LONG    = 2'd2;

    // event kinds
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_LONG    = 2'd1;
    localparam logic [1:0] KIND_RELEASE = 2'd2;
    localparam logic [1:0] KIND_RESET   = 2'd3;

    // job queue between classifier and event sequencer
    localparam int JOB_DEPTH = 2;
    localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    // One classified sample: a first event and an optional follow-up press
    typedef struct packed {
        logic [SLOT_W-1:0]         slot;
        logic [1:0]                kind;
        logic [TAG_W-1:0]          tag;
        logic                      two;
        logic [TAG_W-1:0]          tag2;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_job;

endpackage

/* sv/ttq_queue.sv */
// Short job queue between the sample classifier and the event sequencer
module ttq_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ttq_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output ttq_pkg::t_job o_job,
    input  logic          i_pop
);
    import ttq_pkg::*;

    t_job                 r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [JOB_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [JOB_CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == JOB_CNT_W'(JOB_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* sv/ttq_front.sv */
// Sample classifier: per-slot press state, hold timer compare and job build
module ttq_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ttq_pkg::HOLD_W-1:0]          i_cfg_wr_data,
    input  logic                                i_accept,
    input  logic [ttq_pkg::SLOT_W-1:0]          i_slot_index,
    input  logic [ttq_pkg::TAG_W-1:0]           i_touch_tag,
    input  logic signed [ttq_pkg::COORD_W-1:0]  i_x_coord,
    input  logic signed [ttq_pkg::COORD_W-1:0]  i_y_coord,
    input  logic [ttq_pkg::TIME_W-1:0]          i_now_ms,
    input  logic                                i_gestures_allow,
    output logic                                o_push,
    output ttq_pkg::t_job                       o_job
);
    import ttq_pkg::*;

    logic [HOLD_W-1:0] r_long_press_ms;
    logic [1:0]        r_mode  [NUM_SLOTS];
    logic [TAG_W-1:0]  r_ptag  [NUM_SLOTS];
    logic [TIME_W-1:0] r_start [NUM_SLOTS];

    logic              in_range;
    logic [SLOT_W-1:0] slot_sel;
    logic [1:0]        cur_mode, n_mode;
    logic [TAG_W-1:0]  cur_ptag, n_ptag;
    logic [TIME_W-1:0] cur_start, n_start;
    logic [TIME_W-1:0] hold;
    logic              long_hit;
    logic              released;
    logic              has_event;
    t_job              job;

    assign in_range  = (i_slot_index < SLOT_W'(NUM_SLOTS));
    assign slot_sel  = in_range ? i_slot_index : '0;
    assign cur_mode  = r_mode[slot_sel];
    assign cur_ptag  = r_ptag[slot_sel];
    assign cur_start = r_start[slot_sel];

    // hold time wraps with the millisecond counter
    assign hold      = i_now_ms - cur_start;
    assign long_hit  = (hold > {{(TIME_W-HOLD_W){1'b0}}, r_long_press_ms});
    assign released  = (i_x_coord == RELEASED_XY) && (i_y_coord == RELEASED_XY);

    always_comb begin
        n_mode    = cur_mode;
        n_ptag    = cur_ptag;
        n_start   = cur_start;
        has_event = 1'b0;
        job.slot  = i_slot_index;
        job.kind  = KIND_PRESS;
        job.tag   = i_touch_tag;
        job.two   = 1'b0;
        job.tag2  = i_touch_tag;
        job.x     = i_x_coord;
        job.y     = i_y_coord;
        unique case (cur_mode) inside
            MODE_PRESSED, MODE_LONG: begin
                if (cur_mode == MODE_PRESSED && i_touch_tag == cur_ptag && long_hit) begin
                    has_event = 1'b1;
                    job.kind  = KIND_LONG;
                    n_mode    = MODE_LONG;
                end else if (i_touch_tag != cur_ptag) begin
                    has_event = 1'b1;
                    n_start   = i_now_ms;
                    job.kind  = released ? KIND_RELEASE : KIND_RESET;
                    job.tag   = cur_ptag;
                    n_ptag    = i_touch_tag;
                    if (i_touch_tag != '0) begin
                        job.two = 1'b1;
                        n_mode  = MODE_PRESSED;
                    end else begin
                        n_mode  = MODE_IDLE;
                    end
                end
            end
            default: begin
                // idle: start time tracks the clock
                n_mode  = MODE_IDLE;
                n_start = i_now_ms;
                if (i_touch_tag != '0 && i_gestures_allow) begin
                    has_event = 1'b1;
                    n_ptag    = i_touch_tag;
                    n_mode    = MODE_PRESSED;
                end
            end
        endcase
    end

    assign o_push = i_accept && in_range && has_event;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ms <= LONG_PRESS_RESET;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_mode[i]  <= MODE_IDLE;
                r_ptag[i]  <= '0;
                r_start[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_long_press_ms <= i_cfg_wr_data;
            end
            if (i_accept && in_range) begin
                r_mode[slot_sel]  <= n_mode;
                r_ptag[slot_sel]  <= n_ptag;
                r_start[slot_sel] <= n_start;
            end
        end
    end

endmodule

/* sv/ttq_back.sv */
// Event sequencer: unpacks each job into one or two output words
module ttq_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  ttq_pkg::t_job                       i_q_job,
    output logic                                o_pop,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [ttq_pkg::SLOT_W-1:0]          o_event_slot,
    output logic [1:0]                          o_event_kind,
    output logic [ttq_pkg::TAG_W-1:0]           o_event_tag,
    output logic signed [ttq_pkg::COORD_W-1:0]  o_event_x,
    output logic signed [ttq_pkg::COORD_W-1:0]  o_event_y,
    output logic                                o_last_event
);
    import ttq_pkg::*;

    logic                      r_out_valid;
    logic                      r_second;
    logic [TAG_W-1:0]          r_tag2;
    logic [SLOT_W-1:0]         r_slot;
    logic [1:0]                r_kind;
    logic [TAG_W-1:0]          r_tag;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic                      r_last;
    logic                      load;

    assign load  = !r_out_valid || !i_out_stall;
    assign o_pop = load && !r_second && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else if (load) begin
            if (r_second) begin
                r_out_valid <= 1'b1;
                r_second    <= 1'b0;
            end else if (i_q_valid) begin
                r_out_valid <= 1'b1;
                r_second    <= i_q_job.two;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_second) begin
                r_kind <= KIND_PRESS;
                r_tag  <= r_tag2;
                r_last <= 1'b1;
            end else if (i_q_valid) begin
                r_slot <= i_q_job.slot;
                r_kind <= i_q_job.kind;
                r_tag  <= i_q_job.tag;
                r_tag2 <= i_q_job.tag2;
                r_x    <= i_q_job.x;
                r_y    <= i_q_job.y;
                r_last <= !i_q_job.two;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_event_slot = r_slot;
    assign o_event_kind = r_kind;
    assign o_event_tag  = r_tag;
    assign o_event_x    = r_x;
    assign o_event_y    = r_y;
    assign o_last_event = r_last;

endmodule

/* sv/touch_tag_event_qualifier.sv */
// Top level of the touch tag event qualifier: classifier, job queue, sequencer
//
//  channel   dir  handshake                 payload
//  -------   ---  ------------------------  ---------------------------------------------
//  sample    in   i_in_valid / o_in_stall   slot_index touch_tag x/y now_ms gestures_allow
//  event     out  o_out_valid / i_out_stall event_slot/kind/tag/x/y last_event
//  config    in   i_cfg_wr_en               i_cfg_wr_data (long press threshold, ms)
//
//  A sample word is taken one per cycle while the two-entry job queue has room.
//  Events leave the output register one word per cycle while i_out_stall is low: two words
//  for a release or reset plus a new press, one word for a single event.
//  A sample's job is registered in the job queue, then in the output register.
//  Reset (synchronous, active low) sets all slots idle and the threshold to 1000 ms.
//  o_in_stall rises only when the queue is full; a stalled event word holds.
module touch_tag_event_qualifier (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [ttq_pkg::HOLD_W-1:0]          i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ttq_pkg::SLOT_W-1:0]          i_slot_index,
    input  logic [ttq_pkg::TAG_W-1:0]           i_touch_tag,
    input  logic signed [ttq_pkg::COORD_W-1:0]  i_x_coord,
    input  logic signed [ttq_pkg::COORD_W-1:0]  i_y_coord,
    input  logic [ttq_pkg::TIME_W-1:0]          i_now_ms,
    input  logic                                i_gestures_allow,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ttq_pkg::SLOT_W-1:0]          o_event_slot,
    output logic [1:0]                          o_event_kind,
    output logic [ttq_pkg::TAG_W-1:0]           o_event_tag,
    output logic signed [ttq_pkg::COORD_W-1:0]  o_event_x,
    output logic signed [ttq_pkg::COORD_W-1:0]  o_event_y,
    output logic                                o_last_event
);
    import ttq_pkg::*;

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    logic accept;
    t_job push_job;
    t_job head_job;

    // take a sample word whenever the queue can hold its job
    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    // classify the sample and advance the slot state on the accept edge
    ttq_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_accept         (accept),
        .i_slot_index     (i_slot_index),
        .i_touch_tag      (i_touch_tag),
        .i_x_coord        (i_x_coord),
        .i_y_coord        (i_y_coord),
        .i_now_ms         (i_now_ms),
        .i_gestures_allow (i_gestures_allow),
        .o_push           (push),
        .o_job            (push_job)
    );

    // decouple classification from a stalled output
    ttq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    // drain each job as one or two event words
    ttq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_job      (head_job),
        .o_pop        (pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_event_slot (o_event_slot),
        .o_event_kind (o_event_kind),
        .o_event_tag  (o_event_tag),
        .o_event_x    (o_event_x),
        .o_event_y    (o_event_y),
        .o_last_event (o_last_event)
    );

endmodule

/* sv/ttq_checker.sv */
// Port-level checker for the touch tag event qualifier and its bind
`include "touch_tag_event_qualifier_macros.svh"

module ttq_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [ttq_pkg::SLOT_W-1:0]          o_event_slot,
    input logic [1:0]                          o_event_kind,
    input logic [ttq_pkg::TAG_W-1:0]           o_event_tag,
    input logic signed [ttq_pkg::COORD_W-1:0]  o_event_x,
    input logic signed [ttq_pkg::COORD_W-1:0]  o_event_y,
    input logic                                o_last_event
);
    import ttq_pkg::*;

    // hold a stalled event word
    `TTQ_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_event_slot) && $stable(o_event_kind) && $stable(o_event_tag) && $stable(o_event_x) && $stable(o_event_y) && $stable(o_last_event), "stalled event word changed")

    // a long press always stands alone
    `TTQ_ASSERT_NOW(a_long_single, o_out_valid && o_event_kind == KIND_LONG, o_last_event, "long press not last")

    // only a release or reset opens a pair
    `TTQ_ASSERT_NOW(a_pair_head, o_out_valid && !o_last_event, o_event_kind == KIND_RELEASE || o_event_kind == KIND_RESET, "pair opened by wrong kind")

    // the follow-up press comes next on the same slot
    `TTQ_ASSERT_NEXT(a_pair_tail, o_out_valid && !i_out_stall && !o_last_event, o_out_valid && o_event_kind == KIND_PRESS && o_last_event && o_event_slot == $past(o_event_slot), "follow-up press missing")

    // events come only from real slots
    `TTQ_ASSERT_NOW(a_slot_range, o_out_valid, o_event_slot < SLOT_W'(NUM_SLOTS), "event slot out of range")

endmodule

bind touch_tag_event_qualifier ttq_checker u_ttq_checker (.*);

/* tb/sv/tb_touch_tag_event_checker.sv */
// Event checker for the touch tag event qualifier: predicts events and compares them
`timescale 1ns / 1ps

module tb_touch_tag_event_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [ttq_pkg::HOLD_W-1:0]         i_cfg_wr_data,
    input  logic                               i_sample_valid,
    input  logic                               i_sample_stall,
    input  logic [ttq_pkg::SLOT_W-1:0]         i_slot_index,
    input  logic [ttq_pkg::TAG_W-1:0]          i_touch_tag,
    input  logic signed [ttq_pkg::COORD_W-1:0] i_x_coord,
    input  logic signed [ttq_pkg::COORD_W-1:0] i_y_coord,
    input  logic [ttq_pkg::TIME_W-1:0]         i_now_ms,
    input  logic                               i_gestures_allow,
    input  logic                               i_event_valid,
    input  logic                               i_event_stall,
    input  logic [ttq_pkg::SLOT_W-1:0]         i_event_slot,
    input  logic [1:0]                         i_event_kind,
    input  logic [ttq_pkg::TAG_W-1:0]          i_event_tag,
    input  logic signed [ttq_pkg::COORD_W-1:0] i_event_x,
    input  logic signed [ttq_pkg::COORD_W-1:0] i_event_y,
    input  logic                               i_last_event,
    output int                                 o_mismatches,
    output int                                 o_pending
);
    import ttq_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0]         slot;
        logic [1:0]                kind;
        logic [TAG_W-1:0]          tag;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } t_touch_event;

    logic [1:0]        slot_mode   [NUM_SLOTS];
    logic [TAG_W-1:0]  held_tag    [NUM_SLOTS];
    logic [TIME_W-1:0] press_start [NUM_SLOTS];
    logic [HOLD_W-1:0] long_press_ms;
    t_touch_event      pending_events [$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: event mismatch: %s", $time, msg);
        o_mismatches++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    function automatic t_touch_event make_event(
        input logic [SLOT_W-1:0]         slot,
        input logic [1:0]                kind,
        input logic [TAG_W-1:0]          tag,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y
    );
        t_touch_event ev;
        ev.slot = slot;
        ev.kind = kind;
        ev.tag  = tag;
        ev.x    = x;
        ev.y    = y;
        ev.last = 1'b0;
        return ev;
    endfunction

    // Advance one slot by one sample and queue the events it gives
    task automatic classify_sample(
        input logic [SLOT_W-1:0]         slot,
        input logic [TAG_W-1:0]          tag,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic [TIME_W-1:0]         now,
        input logic                      allow
    );
        t_touch_event      evs [2];
        int                n;
        logic [1:0]        mode;
        logic [TIME_W-1:0] held;
        n = 0;
        if (slot >= SLOT_W'(NUM_SLOTS))
            return;
        mode = slot_mode[slot];
        held = now - press_start[slot];
        if (mode == MODE_PRESSED || mode == MODE_LONG) begin
            if (mode == MODE_PRESSED && tag == held_tag[slot] &&
                held > {{(TIME_W-HOLD_W){1'b0}}, long_press_ms}) begin
                evs[n++] = make_event(slot, KIND_LONG, tag, x, y);
                slot_mode[slot] = MODE_LONG;
            end else if (tag != held_tag[slot]) begin
                press_start[slot] = now;
                if (x == RELEASED_XY && y == RELEASED_XY)
                    evs[n++] = make_event(slot, KIND_RELEASE, held_tag[slot], x, y);
                else
                    evs[n++] = make_event(slot, KIND_RESET, held_tag[slot], x, y);
                held_tag[slot] = tag;
                if (tag != '0) begin
                    evs[n++] = make_event(slot, KIND_PRESS, tag, x, y);
                    slot_mode[slot] = MODE_PRESSED;
                end else begin
                    slot_mode[slot] = MODE_IDLE;
                end
            end
        end else begin
            // idle, and the unused mode code behaves the same
            slot_mode[slot]   = MODE_IDLE;
            press_start[slot] = now;
            if (tag != '0 && allow) begin
                evs[n++] = make_event(slot, KIND_PRESS, tag, x, y);
                held_tag[slot]  = tag;
                slot_mode[slot] = MODE_PRESSED;
            end
        end
        for (int i = 0; i < n; i++) begin
            evs[i].last = (i == n - 1);
            pending_events.push_back(evs[i]);
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_touch_event want;
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                slot_mode[s]   = MODE_IDLE;
                held_tag[s]    = '0;
                press_start[s] = '0;
            end
            long_press_ms = LONG_PRESS_RESET;
            pending_events.delete();
        end else begin
            if (i_event_valid && !i_event_stall) begin
                if (pending_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected word slot %0d kind %0d tag %0d",
                                              i_event_slot, i_event_kind, i_event_tag));
                end else begin
                    want = pending_events.pop_front();
                    check_field("event_slot", longint'(i_event_slot), longint'(want.slot));
                    check_field("event_kind", longint'(i_event_kind), longint'(want.kind));
                    check_field("event_tag", longint'(i_event_tag), longint'(want.tag));
                    check_field("event_x", longint'(i_event_x), longint'(want.x));
                    check_field("event_y", longint'(i_event_y), longint'(want.y));
                    check_field("last_event", longint'(i_last_event), longint'(want.last));
                end
            end
            if (i_cfg_wr_en)
                long_press_ms = i_cfg_wr_data;
            if (i_sample_valid && !i_sample_stall)
                classify_sample(i_slot_index, i_touch_tag, i_x_coord, i_y_coord,
                                i_now_ms, i_gestures_allow);
        end
        o_pending = pending_events.size();
    end

endmodule

/* tb/sv/tb_touch_tag_event_qualifier.sv */
// Top of the touch tag event qualifier testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_touch_tag_event_qualifier;
    import ttq_pkg::*;

    // cycles to let pass once no event word is owed: the block may still be
    // chewing on a sample that gives no event
    localparam int DRAIN_SLACK = 8;
    localparam int PHASE_ITEMS = 400;
    localparam int HOLD_OFF    = 200;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_wr_en;
    logic [HOLD_W-1:0]         i_cfg_wr_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [SLOT_W-1:0]         i_slot_index;
    logic [TAG_W-1:0]          i_touch_tag;
    logic signed [COORD_W-1:0] i_x_coord;
    logic signed [COORD_W-1:0] i_y_coord;
    logic [TIME_W-1:0]         i_now_ms;
    logic                      i_gestures_allow;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [SLOT_W-1:0]         o_event_slot;
    logic [1:0]                o_event_kind;
    logic [TAG_W-1:0]          o_event_tag;
    logic signed [COORD_W-1:0] o_event_x;
    logic signed [COORD_W-1:0] o_event_y;
    logic                      o_last_event;

    int mismatches;
    int event_backlog;

    // stimulus knobs of the sample and event sides
    logic              tx_idle_on;
    logic              rx_idle_on;
    int                rx_hold_cycles;
    logic [HOLD_W-1:0] hold_ms_now;
    logic [TIME_W-1:0] clock_ms;
    logic [TAG_W-1:0]  last_sent_tag [8];

    touch_tag_event_qualifier dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_slot_index     (i_slot_index),
        .i_touch_tag      (i_touch_tag),
        .i_x_coord        (i_x_coord),
        .i_y_coord        (i_y_coord),
        .i_now_ms         (i_now_ms),
        .i_gestures_allow (i_gestures_allow),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_slot     (o_event_slot),
        .o_event_kind     (o_event_kind),
        .o_event_tag      (o_event_tag),
        .o_event_x        (o_event_x),
        .o_event_y        (o_event_y),
        .o_last_event     (o_last_event)
    );

    tb_touch_tag_event_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_sample_valid   (i_in_valid),
        .i_sample_stall   (o_in_stall),
        .i_slot_index     (i_slot_index),
        .i_touch_tag      (i_touch_tag),
        .i_x_coord        (i_x_coord),
        .i_y_coord        (i_y_coord),
        .i_now_ms         (i_now_ms),
        .i_gestures_allow (i_gestures_allow),
        .i_event_valid    (o_out_valid),
        .i_event_stall    (i_out_stall),
        .i_event_slot     (o_event_slot),
        .i_event_kind     (o_event_kind),
        .i_event_tag      (o_event_tag),
        .i_event_x        (o_event_x),
        .i_event_y        (o_event_y),
        .i_last_event     (o_last_event),
        .o_mismatches     (mismatches),
        .o_pending        (event_backlog)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Hand one sample word to the block: if idling is on, idle a random number of
    // cycles first, then hold the word until the block takes it. Valid stays high
    // after the accept edge so back-to-back words need no extra assignment.
    task automatic send_sample(
        input logic [SLOT_W-1:0]         slot,
        input logic [TAG_W-1:0]          tag,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic [TIME_W-1:0]         now,
        input logic                      allow
    );
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_slot_index     <= slot;
        i_touch_tag      <= tag;
        i_x_coord        <= x;
        i_y_coord        <= y;
        i_now_ms         <= now;
        i_gestures_allow <= allow;
        last_sent_tag[slot] = tag;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid and wait until every owed event word has left the block
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (event_backlog != 0) @(negedge i_clk);
        repeat (DRAIN_SLACK) @(negedge i_clk);
    endtask

    task automatic write_long_press(input logic [HOLD_W-1:0] value);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        hold_ms_now = value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Hand-picked samples: threshold edges, time wrap, every event kind,
    // gestures blocking a press, ignored slots, follow-up press ignoring gestures
    task automatic directed_samples();
        send_sample(0, 8'd255, 16'sd32767, -16'sd32767, 32'd0, 1'b1);
        send_sample(0, 8'd255, 16'sd1, 16'sd2, 32'd1000, 1'b1);     // hold equals threshold
        send_sample(0, 8'd255, 16'sd3, 16'sd4, 32'd1001, 1'b1);     // long press
        send_sample(0, 8'd255, 16'sd5, 16'sd6, 32'd90000, 1'b1);    // already long
        send_sample(0, 8'd0, RELEASED_XY, RELEASED_XY, 32'd90001, 1'b1);
        send_sample(1, 8'd1, 16'sd0, 16'sd0, 32'hFFFF_FF00, 1'b0);  // gestures block
        send_sample(1, 8'd1, 16'sd0, 16'sd0, 32'hFFFF_FF00, 1'b1);
        send_sample(1, 8'd1, -16'sd1, -16'sd1, 32'h0000_0300, 1'b1); // hold wraps
        send_sample(1, 8'd2, RELEASED_XY, 16'sd5, 32'h0000_0301, 1'b0);
        send_sample(1, 8'd3, 16'sd5, RELEASED_XY, 32'h0000_0302, 1'b0);
        send_sample(1, 8'd0, RELEASED_XY, RELEASED_XY, 32'h0000_0303, 1'b0);
        send_sample(7, 8'd9, 16'sd9, 16'sd9, 32'd0, 1'b1);          // no such slot
        send_sample(5, 8'd200, 16'sd9, 16'sd9, 32'd0, 1'b1);
        send_sample(6, 8'd77, RELEASED_XY, RELEASED_XY, 32'd5, 1'b0);
        send_sample(4, 8'd0, 16'sd0, 16'sd0, 32'd6, 1'b1);
        send_sample(4, 8'd128, RELEASED_XY, RELEASED_XY, 32'd10, 1'b1);
        send_sample(4, 8'd77, RELEASED_XY, RELEASED_XY, 32'd11, 1'b1);
        send_sample(4, 8'd0, -16'sd1, 16'sd0, 32'd12, 1'b1);
        send_sample(2, 8'h55, 16'sd0, 16'sd0, 32'hFFFF_FFFF, 1'b1);
        send_sample(2, 8'h55, 16'sd0, 16'sd0, 32'hFFFF_FFFF, 1'b1);
        send_sample(3, 8'hAA, RELEASED_XY, 16'sd7, 32'd100, 1'b1);
        send_sample(3, 8'hAA, 16'sd7, 16'sd7, 32'd1100, 1'b1);
        send_sample(3, 8'hAA, 16'sd7, 16'sd7, 32'd1101, 1'b1);
        send_sample(3, 8'h55, 16'sd8, 16'sd8, 32'd1102, 1'b1);      // reset from long
    endtask

    // Mostly plausible touch traffic: per slot a tag is held, changed or lifted
    // while time moves on at a pace scaled to the threshold; a few words are noise
    task automatic random_sample();
        logic [SLOT_W-1:0]         slot;
        logic [TAG_W-1:0]          tag;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      allow;
        int                        pick;
        int                        span;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            slot     = SLOT_W'($urandom);
            tag      = TAG_W'($urandom);
            x        = COORD_W'($urandom);
            y        = COORD_W'($urandom);
            clock_ms = $urandom;
            allow    = 1'($urandom);
        end else begin
            slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
            span = int'(hold_ms_now) / 3 + 2;
            pick = $urandom_range(0, 99);
            if (pick < 6)
                clock_ms = clock_ms + TIME_W'(hold_ms_now) + $urandom_range(1, 3);
            else if (pick < 8)
                clock_ms = clock_ms + $urandom;
            else
                clock_ms = clock_ms + $urandom_range(0, span);
            pick = $urandom_range(0, 99);
            if (last_sent_tag[slot] != '0)
                tag = (pick < 60) ? last_sent_tag[slot] :
                      (pick < 80) ? 8'd0 : 8'($urandom_range(1, 255));
            else
                tag = (pick < 50) ? 8'($urandom_range(1, 255)) : 8'd0;
            pick = $urandom_range(0, 9);
            if (tag == '0 && pick < 7) begin
                x = RELEASED_XY;
                y = RELEASED_XY;
            end else if (pick == 9) begin
                x = RELEASED_XY;
                y = COORD_W'($urandom);
            end else begin
                x = COORD_W'($urandom);
                y = COORD_W'($urandom);
            end
            allow = ($urandom_range(0, 7) != 0);
        end
        send_sample(slot, tag, x, y, clock_ms, allow);
    endtask

    // Random traffic with idling switched per stretch and occasional full drains
    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0) begin
                tx_idle_on = ($urandom_range(0, 2) != 0);
                rx_idle_on = ($urandom_range(0, 2) != 0);
                if ($urandom_range(0, 3) == 0)
                    wait_drained();
            end
            random_sample();
        end
    endtask

    // Event side: if idling is on, stall a random number of cycles per word, or
    // hold off for a long stretch when asked
    initial begin : event_sink
        int stall_cycles;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall_cycles   = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall_cycles = rx_idle_on ? $urandom_range(0, 19) : 0;
            end
            if (stall_cycles > 0) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (stall_cycles - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin : sample_source
        i_rst_n          = 1'b0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_wr_data    = '0;
        i_in_valid       = 1'b0;
        i_slot_index     = '0;
        i_touch_tag      = '0;
        i_x_coord        = '0;
        i_y_coord        = '0;
        i_now_ms         = '0;
        i_gestures_allow = 1'b0;
        tx_idle_on       = 1'b1;
        rx_idle_on       = 1'b1;
        rx_hold_cycles   = 0;
        hold_ms_now      = LONG_PRESS_RESET;
        clock_ms         = 32'd2000;
        for (int s = 0; s < 8; s++)
            last_sent_tag[s] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset threshold first, then the extremes and a few in between
        directed_samples();
        random_phase(PHASE_ITEMS);
        write_long_press('0);
        random_phase(PHASE_ITEMS);
        write_long_press('1);
        random_phase(PHASE_ITEMS);

        // stall the event side for a long stretch while samples keep coming
        // back to back, so the job queue fills and the input stalls
        write_long_press(16'd1);
        tx_idle_on     = 1'b0;
        rx_hold_cycles = HOLD_OFF;
        repeat (30) random_sample();
        wait_drained();
        random_phase(PHASE_ITEMS - 30);

        write_long_press(16'($urandom_range(2, 3000)));
        random_phase(PHASE_ITEMS);

        wait_drained();
        if (mismatches == 0 && event_backlog == 0)
            $display("touch_tag_event_qualifier verification clean");
        else
            $display("touch_tag_event_qualifier verification failed");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("touch_tag_event_qualifier verification failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/ttq_pkg.sv
sv/ttq_queue.sv
sv/ttq_front.sv
sv/ttq_back.sv
sv/touch_tag_event_qualifier.sv
sv/ttq_checker.sv
tb/sv/tb_touch_tag_event_checker.sv
tb/sv/tb_touch_tag_event_qualifier.sv
